// ===== rtl/bounded_byte_stream_fifo_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bounded byte stream FIFO
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_BYTE_STREAM_FIFO_ASSERT_SVH
`define BOUNDED_BYTE_STREAM_FIFO_ASSERT_SVH

// same-cycle implication
`define BBSF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BBSF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bbsf_pkg.sv =====
// ----------------------------------------------------------------------------
// bbsf_pkg
// Shared types and constants of the bounded byte stream FIFO.
// ----------------------------------------------------------------------------
package bbsf_pkg;

   // byte store size; pointers follow from it, counts are 13 bits wide
   localparam int STORE_DEPTH    = 4096;
   localparam int PTR_W          = $clog2(STORE_DEPTH);
   localparam int CNT_W          = 13;
   localparam int SUM_W          = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
   localparam int TOT_W          = 64;
   localparam int CAPACITY_RESET = 4096;

   // op codes
   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_CLOSE = 2'd2;

   typedef struct packed {
      logic [1:0]       op;
      logic [7:0]       data_byte;
      logic [CNT_W-1:0] pop_count;
   } req_payload_type;

   typedef struct packed {
      logic             accepted;
      logic             front_valid;
      logic [7:0]       front_byte;
      logic [CNT_W-1:0] buffered_bytes;
      logic [CNT_W-1:0] free_bytes;
      logic [TOT_W-1:0] pushed_total;
      logic [TOT_W-1:0] popped_total;
      logic             closed;
      logic             finished;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic execute;
      logic load_rsp;
   } ctl_cmd_type;

endpackage

// ===== rtl/bounded_byte_stream_fifo.sv =====
// ----------------------------------------------------------------------------
// bounded_byte_stream_fifo
// Byte FIFO with programmable capacity and a sticky end-of-stream mark.
// ----------------------------------------------------------------------------
//
//   channel   ports                          direction  word
//   req       req_valid/req_ready/req_payload  in       push, pop N or close
//   rsp       rsp_valid/rsp_ready/rsp_payload  out      status after the op
//   csr       csr_valid/csr_ready/csr_data     in       capacity in use
//
// An item passes through the sequencer steps in order: accept, execute
// (pointer, count and total update, store write), front byte read through
// the registered store port, response load. The next word can be taken
// only once the sequencer is back in idle; the store's registered read port
// adds the read step. The response sits in an output register, so the next
// word is taken while it waits; a stalled rsp only holds the load step.
// Reset is synchronous; the byte store is not cleared (only buffered
// entries are ever read), so there is no clearing pass.
// ----------------------------------------------------------------------------
module bounded_byte_stream_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bbsf_pkg::req_payload_type     req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bbsf_pkg::rsp_payload_type     rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bbsf_pkg::CNT_W-1:0]    csr_data
);

   bbsf_pkg::ctl_cmd_type cmd;

   // capacity writes are taken any cycle; the user must send them only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   // sequencer
   bbsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // store, counters and response register
   bbsf_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/bbsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbsf_ctrl
// Sequencer: take a word, execute, read the front byte, load the response.
// ----------------------------------------------------------------------------
module bbsf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bbsf_pkg::ctl_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_READ = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free     = !rsp_valid_ff || rsp_ready;
   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;

   assign cmd.load_item = req_valid && req_ready;
   assign cmd.execute   = (state_ff == ST_EXEC);
   assign cmd.load_rsp  = (state_ff == ST_DONE) && slot_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: state_in = ST_READ;
         ST_READ: state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/bbsf_dpath.sv =====
// ----------------------------------------------------------------------------
// bbsf_dpath
// Byte store, pointers, counts, totals, capacity register, response register.
// ----------------------------------------------------------------------------
module bbsf_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  bbsf_pkg::ctl_cmd_type              cmd,
   input  bbsf_pkg::req_payload_type          req_payload,
   input  logic                               csr_write,
   input  logic [bbsf_pkg::CNT_W-1:0]         csr_data,
   output bbsf_pkg::rsp_payload_type          rsp_payload
);

   localparam int PTR_W = bbsf_pkg::PTR_W;
   localparam int CNT_W = bbsf_pkg::CNT_W;
   localparam int SUM_W = bbsf_pkg::SUM_W;
   localparam int TOT_W = bbsf_pkg::TOT_W;

   logic [7:0]                byte_store_ff [bbsf_pkg::STORE_DEPTH];
   bbsf_pkg::req_payload_type item_ff;
   bbsf_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic [CNT_W-1:0]          capacity_ff;
   logic [PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]          held_ff, held_in;
   logic [TOT_W-1:0]          push_total_ff, push_total_in;
   logic [TOT_W-1:0]          pop_total_ff, pop_total_in;
   logic                      closed_ff, closed_in;
   logic                      accepted_ff, accepted_in;
   logic [7:0]                rd_data_ff;

   logic [CNT_W-1:0]          cap_eff;
   logic                      push_ok, pop_ok, close_ok;
   logic [SUM_W-1:0]          rd_sum;

   // capacity saturates at the store depth
   assign cap_eff = (capacity_ff > CNT_W'(bbsf_pkg::STORE_DEPTH))
                    ? CNT_W'(bbsf_pkg::STORE_DEPTH) : capacity_ff;

   assign push_ok  = (item_ff.op == bbsf_pkg::OP_PUSH) && !closed_ff && (held_ff < cap_eff);
   assign pop_ok   = (item_ff.op == bbsf_pkg::OP_POP) && (held_ff != '0)
                     && (item_ff.pop_count <= held_ff);
   assign close_ok = (item_ff.op == bbsf_pkg::OP_CLOSE);

   assign rd_sum   = SUM_W'(rd_ptr_ff) + SUM_W'(item_ff.pop_count);

   always_comb begin
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      held_in       = held_ff;
      push_total_in = push_total_ff;
      pop_total_in  = pop_total_ff;
      closed_in     = closed_ff;
      accepted_in   = push_ok || pop_ok || close_ok;
      if (push_ok) begin
         wr_ptr_in     = (wr_ptr_ff == PTR_W'(bbsf_pkg::STORE_DEPTH - 1))
                         ? '0 : wr_ptr_ff + PTR_W'(1);
         held_in       = held_ff + CNT_W'(1);
         push_total_in = push_total_ff + TOT_W'(1);
      end
      if (pop_ok) begin
         // pop count never exceeds the depth, so one wrap is enough
         rd_ptr_in    = (rd_sum >= SUM_W'(bbsf_pkg::STORE_DEPTH))
                        ? PTR_W'(rd_sum - SUM_W'(bbsf_pkg::STORE_DEPTH))
                        : PTR_W'(rd_sum);
         held_in      = held_ff - item_ff.pop_count;
         pop_total_in = pop_total_ff + TOT_W'(item_ff.pop_count);
      end
      if (close_ok) begin
         closed_in = 1'b1;
      end
   end

   always_comb begin
      rsp_in.accepted       = accepted_ff;
      rsp_in.front_valid    = (held_ff != '0);
      rsp_in.front_byte     = (held_ff != '0) ? rd_data_ff : 8'd0;
      rsp_in.buffered_bytes = held_ff;
      rsp_in.free_bytes     = (cap_eff > held_ff) ? (cap_eff - held_ff) : '0;
      rsp_in.pushed_total   = push_total_ff;
      rsp_in.popped_total   = pop_total_ff;
      rsp_in.closed         = closed_ff;
      rsp_in.finished       = closed_ff && (held_ff == '0);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CNT_W'(bbsf_pkg::CAPACITY_RESET);
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         held_ff       <= '0;
         push_total_ff <= '0;
         pop_total_ff  <= '0;
         closed_ff     <= 1'b0;
      end else begin
         if (csr_write) capacity_ff <= csr_data;
         if (cmd.execute) begin
            rd_ptr_ff     <= rd_ptr_in;
            wr_ptr_ff     <= wr_ptr_in;
            held_ff       <= held_in;
            push_total_ff <= push_total_in;
            pop_total_ff  <= pop_total_in;
            closed_ff     <= closed_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) item_ff     <= req_payload;
      if (cmd.execute)   accepted_ff <= accepted_in;
      if (cmd.load_rsp)  rsp_ff      <= rsp_in;
   end

   // byte store: one write port, one registered read port at the front
   always_ff @(posedge clock) begin
      if (cmd.execute && push_ok) byte_store_ff[wr_ptr_ff] <= item_ff.data_byte;
      rd_data_ff <= byte_store_ff[rd_ptr_ff];
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/bbsf_checker.sv =====
// ----------------------------------------------------------------------------
// bbsf_checker
// Port-level checks of the bounded byte stream FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_byte_stream_fifo_assert.svh"

module bbsf_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input bbsf_pkg::rsp_payload_type rsp_payload
);

   // stalled response holds
   `BBSF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "rsp word changed while stalled")

   // one word in flight: no accept right after an accept
   `BBSF_ASSERT_NEXT(a_req_busy, req_valid && req_ready, !req_ready, "req taken while busy")

   // finished means closed and drained
   `BBSF_ASSERT_NOW(a_finished, rsp_valid, rsp_payload.finished == (rsp_payload.closed && (rsp_payload.buffered_bytes == '0)), "finished flag inconsistent")

   // close is sticky until reset
   `BBSF_ASSERT_NEXT(a_closed_sticky, rsp_valid && rsp_ready && rsp_payload.closed, !rsp_valid || rsp_payload.closed, "closed flag dropped")

endmodule

bind bounded_byte_stream_fifo bbsf_checker u_checker (.*);
